[design/assert_macros.svh]
// Assertion macros shared by the processor ID table RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cidt_pkg.sv]
// Shared types and constants for the processor ID table.
// No dependencies; used by the comparator, the top-level module and the testbench.
`timescale 1ns / 1ps

package cidt_pkg;

  localparam int MAX_CPUS_DEF = 64;
  localparam int ID_W         = 8;
  localparam int SLOT_W       = 6;

  typedef enum logic [2:0] {
    CMD_LOAD           = 3'd0,
    CMD_FINISH         = 3'd1,
    CMD_PROC_FROM_ID   = 3'd2,
    CMD_CONTIG_FROM_ID = 3'd3,
    CMD_ID_FROM_PROC   = 3'd4,
    CMD_ID_FROM_CONTIG = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ALL_ZERO   = 3'd1,
    ST_NOT_UNIQUE = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_BAD_INDEX  = 3'd4,
    ST_NOT_READY  = 3'd5,
    ST_TABLE_FULL = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORT_RDP,
    S_SORT_LDV,
    S_SORT_RDS,
    S_SORT_CMP,
    S_SORT_PUT,
    S_VERDICT,
    S_FILL,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_IDX,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

[design/cidt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies on the package.
`timescale 1ns / 1ps

module cidt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/cidt_cmp.sv]
// Shared 8-bit magnitude comparator used by the sort and the ID scan.
// Depends on cidt_pkg for the result struct.
`timescale 1ns / 1ps

module cidt_cmp (
  input  logic [cidt_pkg::ID_W-1:0] a,
  input  logic [cidt_pkg::ID_W-1:0] b,
  output cidt_pkg::cmp_res_t        res
);

  always_comb begin
    res.eq = (a == b);
    res.gt = (a > b);
  end

endmodule

[design/cpu_id_table_validate_and_map.sv]
// Processor ID table: every command transaction returns exactly one result transaction.
// A load, a repeated or empty finish, an unused code and any lookup that fails its
// checks go from acceptance to S_EMIT and the result register; an index lookup passes
// S_IDX first, and an ID lookup S_SCAN_RD and S_SCAN_CMP per entry it scans. A finish
// over n entries runs an insertion sort through the sorted-table memory and one shared
// comparator: per entry S_SORT_RDP, S_SORT_LDV, S_SORT_RDS and S_SORT_CMP for each
// compare against the sorted part, and S_SORT_PUT; then S_VERDICT, S_FILL per entry to
// write the identity map when validation fails, and S_EMIT into the result register.
// One read port per table memory and the shared comparator keep these steps serial.
// The block takes no new transaction until the current one has reached the result
// register, but it does accept one while an earlier result waits to be taken.
// Depends on cidt_pkg, cidt_ram, cidt_cmp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpu_id_table_validate_and_map #(
  parameter int MAX_CPUS = cidt_pkg::MAX_CPUS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_cpu_id,
  input  logic [5:0] in_slot,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_id_out,
  output logic [5:0] out_index_out,
  output logic [2:0] out_status,
  output logic       out_reliable
);

  localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CW = $clog2(MAX_CPUS + 1);
  localparam int SW = (CW > cidt_pkg::SLOT_W) ? CW : cidt_pkg::SLOT_W;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_CPUS);

  // Control state.
  cidt_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              finished_r, finished_nxt;
  logic              ids_valid_r, ids_valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers of the sequencer.
  logic [AW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic [7:0]        v_r, v_nxt;
  logic [7:0]        key_r, key_nxt;
  logic              tab_sel_r, tab_sel_nxt;
  logic [5:0]        slot_r, slot_nxt;
  logic              nonzero_r, nonzero_nxt;
  logic              dup_r, dup_nxt;
  logic [7:0]        res_id_r, res_id_nxt;
  logic [5:0]        res_idx_r, res_idx_nxt;
  cidt_pkg::status_t res_status_r, res_status_nxt;

  // Result register.
  logic [7:0]        out_id_r;
  logic [5:0]        out_idx_r;
  cidt_pkg::status_t out_status_r;
  logic              out_rel_r;

  // Memory ports.
  logic              proc_we, sorted_we;
  logic [AW-1:0]     proc_wa, proc_ra, sorted_wa, sorted_ra;
  logic [7:0]        proc_wd, sorted_wd, proc_rd, sorted_rd;

  // Shared comparator.
  logic [7:0]         cmp_a, cmp_b;
  cidt_pkg::cmp_res_t cmp;

  logic              in_acc;
  logic              out_free;
  cidt_pkg::cmd_t    cmd;
  logic [CW-1:0]     count_eff;
  logic              last_i;
  logic              slot_bad;
  logic [7:0]        tab_rd;
  cidt_pkg::status_t verdict;

  // Terms used by the checks at the end.
  logic              in_fill;
  logic              in_sort_cmp;
  logic              in_emit;
  logic              early_lookup;
  logic              full_shown;

  assign in_stall  = (state_r != cidt_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cmd       = cidt_pkg::cmd_t'(in_cmd);
  // A load after finish starts a new table from entry zero.
  assign count_eff = finished_r ? '0 : count_r;
  assign last_i    = ((CW'(i_r) + CW'(1)) == count_r);
  assign slot_bad  = (SW'(in_slot) >= SW'(count_r));
  assign tab_rd    = tab_sel_r ? sorted_rd : proc_rd;

  assign cmp_a = (state_r == cidt_pkg::S_SORT_CMP) ? sorted_rd : tab_rd;
  assign cmp_b = (state_r == cidt_pkg::S_SORT_CMP) ? v_r : key_r;

  // More than one entry, all zero, outranks the duplicate check.
  always_comb begin
    if ((count_r > CW'(1)) && !nonzero_r) begin
      verdict = cidt_pkg::ST_ALL_ZERO;
    end else if (dup_r) begin
      verdict = cidt_pkg::ST_NOT_UNIQUE;
    end else begin
      verdict = cidt_pkg::ST_OK;
    end
  end

  cidt_ram #(.WIDTH(cidt_pkg::ID_W), .DEPTH(MAX_CPUS), .ADDR_W(AW)) u_proc_ram (
    .clk     (clk),
    .wr_en   (proc_we),
    .wr_addr (proc_wa),
    .wr_data (proc_wd),
    .rd_addr (proc_ra),
    .rd_data (proc_rd)
  );

  cidt_ram #(.WIDTH(cidt_pkg::ID_W), .DEPTH(MAX_CPUS), .ADDR_W(AW)) u_sorted_ram (
    .clk     (clk),
    .wr_en   (sorted_we),
    .wr_addr (sorted_wa),
    .wr_data (sorted_wd),
    .rd_addr (sorted_ra),
    .rd_data (sorted_rd)
  );

  cidt_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cidt_pkg::S_IDLE: begin
        if (in_acc) begin
          case (cmd)
            cidt_pkg::CMD_FINISH: begin
              if (finished_r || (count_r == '0)) begin
                state_nxt = cidt_pkg::S_EMIT;
              end else begin
                state_nxt = cidt_pkg::S_SORT_RDP;
              end
            end
            cidt_pkg::CMD_PROC_FROM_ID, cidt_pkg::CMD_CONTIG_FROM_ID: begin
              if (!finished_r || (count_r == '0)) begin
                state_nxt = cidt_pkg::S_EMIT;
              end else begin
                state_nxt = cidt_pkg::S_SCAN_RD;
              end
            end
            cidt_pkg::CMD_ID_FROM_PROC, cidt_pkg::CMD_ID_FROM_CONTIG: begin
              if (!finished_r || slot_bad) begin
                state_nxt = cidt_pkg::S_EMIT;
              end else begin
                state_nxt = cidt_pkg::S_IDX;
              end
            end
            default: state_nxt = cidt_pkg::S_EMIT;
          endcase
        end
      end
      cidt_pkg::S_SORT_RDP: state_nxt = cidt_pkg::S_SORT_LDV;
      cidt_pkg::S_SORT_LDV: begin
        state_nxt = (i_r == '0) ? cidt_pkg::S_SORT_PUT : cidt_pkg::S_SORT_RDS;
      end
      cidt_pkg::S_SORT_RDS: state_nxt = cidt_pkg::S_SORT_CMP;
      cidt_pkg::S_SORT_CMP: begin
        if (cmp.gt && (j_r != AW'(1))) begin
          state_nxt = cidt_pkg::S_SORT_RDS;
        end else begin
          state_nxt = cidt_pkg::S_SORT_PUT;
        end
      end
      cidt_pkg::S_SORT_PUT: begin
        state_nxt = last_i ? cidt_pkg::S_VERDICT : cidt_pkg::S_SORT_RDP;
      end
      cidt_pkg::S_VERDICT: begin
        state_nxt = (verdict == cidt_pkg::ST_OK) ? cidt_pkg::S_EMIT : cidt_pkg::S_FILL;
      end
      cidt_pkg::S_FILL: begin
        state_nxt = last_i ? cidt_pkg::S_EMIT : cidt_pkg::S_FILL;
      end
      cidt_pkg::S_SCAN_RD: state_nxt = cidt_pkg::S_SCAN_CMP;
      cidt_pkg::S_SCAN_CMP: begin
        state_nxt = (cmp.eq || last_i) ? cidt_pkg::S_EMIT : cidt_pkg::S_SCAN_RD;
      end
      cidt_pkg::S_IDX: state_nxt = cidt_pkg::S_EMIT;
      cidt_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = cidt_pkg::S_IDLE;
        end
      end
      default: state_nxt = cidt_pkg::S_IDLE;
    endcase
  end

  // Memory controls. Read data is registered, so it appears in the cycle after the address.
  always_comb begin
    proc_we   = 1'b0;
    proc_wa   = AW'(count_eff);
    proc_wd   = in_cpu_id;
    proc_ra   = AW'(in_slot);
    sorted_we = 1'b0;
    sorted_wa = j_r;
    sorted_wd = v_r;
    sorted_ra = AW'(in_slot);
    case (state_r)
      cidt_pkg::S_IDLE: begin
        proc_we = in_acc && (cmd == cidt_pkg::CMD_LOAD) && (count_eff != COUNT_MAX);
      end
      cidt_pkg::S_SORT_RDP: proc_ra = i_r;
      cidt_pkg::S_SORT_RDS: sorted_ra = j_r - AW'(1);
      cidt_pkg::S_SORT_CMP: begin
        sorted_we = cmp.gt;
        sorted_wd = sorted_rd;
      end
      cidt_pkg::S_SORT_PUT: sorted_we = 1'b1;
      cidt_pkg::S_FILL: begin
        proc_we   = 1'b1;
        proc_wa   = i_r;
        proc_wd   = 8'(i_r);
        sorted_we = 1'b1;
        sorted_wa = i_r;
        sorted_wd = 8'(i_r);
      end
      cidt_pkg::S_SCAN_RD: begin
        proc_ra   = i_r;
        sorted_ra = i_r;
      end
      default: ;
    endcase
  end

  // Datapath and table bookkeeping.
  always_comb begin
    count_nxt      = count_r;
    finished_nxt   = finished_r;
    ids_valid_nxt  = ids_valid_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    v_nxt          = v_r;
    key_nxt        = key_r;
    tab_sel_nxt    = tab_sel_r;
    slot_nxt       = slot_r;
    nonzero_nxt    = nonzero_r;
    dup_nxt        = dup_r;
    res_id_nxt     = res_id_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    case (state_r)
      cidt_pkg::S_IDLE: begin
        if (in_acc) begin
          res_id_nxt     = '0;
          res_idx_nxt    = '0;
          res_status_nxt = cidt_pkg::ST_OK;
          key_nxt        = in_cpu_id;
          tab_sel_nxt    = (cmd inside {cidt_pkg::CMD_CONTIG_FROM_ID,
                                        cidt_pkg::CMD_ID_FROM_CONTIG});
          slot_nxt       = in_slot;
          i_nxt          = '0;
          nonzero_nxt    = 1'b0;
          dup_nxt        = 1'b0;
          case (cmd)
            cidt_pkg::CMD_LOAD: begin
              finished_nxt = 1'b0;
              if (count_eff == COUNT_MAX) begin
                res_status_nxt = cidt_pkg::ST_TABLE_FULL;
                count_nxt      = count_eff;
              end else begin
                count_nxt = count_eff + CW'(1);
              end
            end
            cidt_pkg::CMD_FINISH: begin
              // An empty table validates at once; the sort path handles the rest.
              if (!finished_r && (count_r == '0)) begin
                finished_nxt  = 1'b1;
                ids_valid_nxt = 1'b1;
              end
            end
            cidt_pkg::CMD_PROC_FROM_ID, cidt_pkg::CMD_CONTIG_FROM_ID: begin
              if (!finished_r) begin
                res_status_nxt = cidt_pkg::ST_NOT_READY;
              end else if (count_r == '0) begin
                res_status_nxt = cidt_pkg::ST_NOT_FOUND;
              end
            end
            cidt_pkg::CMD_ID_FROM_PROC, cidt_pkg::CMD_ID_FROM_CONTIG: begin
              if (!finished_r) begin
                res_status_nxt = cidt_pkg::ST_NOT_READY;
              end else if (slot_bad) begin
                res_status_nxt = cidt_pkg::ST_BAD_INDEX;
              end
            end
            default: ;
          endcase
        end
      end
      cidt_pkg::S_SORT_LDV: begin
        v_nxt       = proc_rd;
        nonzero_nxt = nonzero_r | (proc_rd != '0);
        j_nxt       = i_r;
      end
      cidt_pkg::S_SORT_CMP: begin
        // Everything above the stop point is larger, so an equal value can only
        // sit directly below the insertion slot.
        if (cmp.gt) begin
          j_nxt = j_r - AW'(1);
        end else if (cmp.eq) begin
          dup_nxt = 1'b1;
        end
      end
      cidt_pkg::S_SORT_PUT: begin
        if (!last_i) begin
          i_nxt = i_r + AW'(1);
        end
      end
      cidt_pkg::S_VERDICT: begin
        finished_nxt   = 1'b1;
        res_status_nxt = verdict;
        ids_valid_nxt  = (verdict == cidt_pkg::ST_OK);
        i_nxt          = '0;
      end
      cidt_pkg::S_FILL: begin
        if (!last_i) begin
          i_nxt = i_r + AW'(1);
        end
      end
      cidt_pkg::S_SCAN_CMP: begin
        if (cmp.eq) begin
          res_idx_nxt = 6'(i_r);
        end else if (last_i) begin
          res_status_nxt = cidt_pkg::ST_NOT_FOUND;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      cidt_pkg::S_IDX: begin
        res_id_nxt  = tab_rd;
        res_idx_nxt = slot_r;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = ((state_r == cidt_pkg::S_EMIT) && out_free) ||
                         (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cidt_pkg::S_IDLE;
      count_r     <= '0;
      finished_r  <= 1'b0;
      ids_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      finished_r  <= finished_nxt;
      ids_valid_r <= ids_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    v_r          <= v_nxt;
    key_r        <= key_nxt;
    tab_sel_r    <= tab_sel_nxt;
    slot_r       <= slot_nxt;
    nonzero_r    <= nonzero_nxt;
    dup_r        <= dup_nxt;
    res_id_r     <= res_id_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    if ((state_r == cidt_pkg::S_EMIT) && out_free) begin
      out_id_r     <= res_id_r;
      out_idx_r    <= res_idx_r;
      out_status_r <= res_status_r;
      out_rel_r    <= ids_valid_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_id_out    = out_id_r;
  assign out_index_out = out_idx_r;
  assign out_status    = out_status_r;
  assign out_reliable  = out_rel_r;

  assign in_fill      = (state_r == cidt_pkg::S_FILL);
  assign in_sort_cmp  = (state_r == cidt_pkg::S_SORT_CMP);
  assign in_emit      = (state_r == cidt_pkg::S_EMIT);
  assign early_lookup = in_acc && !finished_r &&
                        (cmd inside {[cidt_pkg::CMD_PROC_FROM_ID :
                                      cidt_pkg::CMD_ID_FROM_CONTIG]});
  assign full_shown   = out_valid_r && (out_status_r == cidt_pkg::ST_TABLE_FULL);

  `ASSERT_IMPL(a_fill_clears_reliable, in_fill, !ids_valid_r, "identity fill while reliable")
  `ASSERT_IMPL(a_sort_load_phase, in_sort_cmp, !finished_r && (j_r != '0), "bad sort compare")
  `ASSERT_NEXT(a_early_lookup_short, early_lookup, in_emit, "early lookup not answered at once")
  `ASSERT_IMPL(a_full_at_capacity, full_shown, count_r == COUNT_MAX, "table_full too early")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cpu_id_table_validate_and_map: a table of directed probes,
// then random load/finish/lookup sessions checked against a behavioral table model.
// Depends on cidt_pkg and the RTL of the block.

module testbench;

  localparam int TABLE_DEPTH  = cidt_pkg::MAX_CPUS_DEF;
  localparam int ITEM_TARGET  = 850;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int PROBE_COUNT  = 26;

  // Codes the block leaves unused; it must answer them with an empty OK result.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [7:0]        id;
    logic [5:0]        idx;
    cidt_pkg::status_t status;
    logic              reliable;
  } table_reply_t;

  typedef struct packed {
    logic [2:0]   cmd;
    logic [7:0]   cpu_id;
    logic [5:0]   slot;
    bit           fixed;
    table_reply_t reply;
  } probe_row_t;

  localparam table_reply_t NO_REPLY = '{8'd0, 6'd0, cidt_pkg::ST_OK, 1'b0};

  // Rows marked fixed carry their expected answer; the rest go through the
  // table model.
  localparam probe_row_t PROBES [PROBE_COUNT] = '{
    '{cidt_pkg::CMD_PROC_FROM_ID, 8'd0, 6'd0, 1'b1,
      '{8'd0, 6'd0, cidt_pkg::ST_NOT_READY, 1'b0}},
    '{cidt_pkg::CMD_FINISH, 8'd0, 6'd0, 1'b1, '{8'd0, 6'd0, cidt_pkg::ST_OK, 1'b1}},
    '{cidt_pkg::CMD_FINISH, 8'd255, 6'd63, 1'b1, '{8'd0, 6'd0, cidt_pkg::ST_OK, 1'b1}},
    '{cidt_pkg::CMD_ID_FROM_PROC, 8'd0, 6'd0, 1'b1,
      '{8'd0, 6'd0, cidt_pkg::ST_BAD_INDEX, 1'b1}},
    '{cidt_pkg::CMD_PROC_FROM_ID, 8'd0, 6'd0, 1'b1,
      '{8'd0, 6'd0, cidt_pkg::ST_NOT_FOUND, 1'b1}},
    '{cidt_pkg::CMD_LOAD, 8'd0, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_FINISH, 8'd0, 6'd0, 1'b1, '{8'd0, 6'd0, cidt_pkg::ST_OK, 1'b1}},
    '{cidt_pkg::CMD_ID_FROM_PROC, 8'd0, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_LOAD, 8'd0, 6'd63, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_LOAD, 8'd0, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_FINISH, 8'd0, 6'd0, 1'b1,
      '{8'd0, 6'd0, cidt_pkg::ST_ALL_ZERO, 1'b0}},
    '{cidt_pkg::CMD_ID_FROM_CONTIG, 8'd255, 6'd1, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_LOAD, 8'd255, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_LOAD, 8'd7, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_LOAD, 8'd255, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_FINISH, 8'd0, 6'd0, 1'b1,
      '{8'd0, 6'd0, cidt_pkg::ST_NOT_UNIQUE, 1'b0}},
    '{cidt_pkg::CMD_PROC_FROM_ID, 8'd255, 6'd0, 1'b1,
      '{8'd0, 6'd0, cidt_pkg::ST_NOT_FOUND, 1'b0}},
    '{cidt_pkg::CMD_LOAD, 8'd200, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_LOAD, 8'd255, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_LOAD, 8'd3, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_FINISH, 8'd0, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_CONTIG_FROM_ID, 8'd255, 6'd0, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_ID_FROM_PROC, 8'd0, 6'd1, 1'b0, NO_REPLY},
    '{cidt_pkg::CMD_ID_FROM_CONTIG, 8'd0, 6'd63, 1'b1,
      '{8'd0, 6'd0, cidt_pkg::ST_BAD_INDEX, 1'b1}},
    '{CMD_SPARE6, 8'd255, 6'd63, 1'b0, NO_REPLY},
    '{CMD_SPARE7, 8'd255, 6'd63, 1'b0, NO_REPLY}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_cmd = '0;
  logic [7:0] in_cpu_id = '0;
  logic [5:0] in_slot = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_id_out;
  logic [5:0] out_index_out;
  logic [2:0] out_status;
  logic       out_reliable;

  // Behavioral copy of the block's tables and flags.
  logic [7:0] proc_ids   [TABLE_DEPTH];
  logic [7:0] sorted_ids [TABLE_DEPTH];
  int         entry_total = 0;
  bit         table_closed = 1'b0;
  bit         ids_trusted = 1'b0;

  table_reply_t replies_due [$];
  int items_sent = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_request = 1'b0;

  always #10 clk = ~clk;

  cpu_id_table_validate_and_map uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_cpu_id     (in_cpu_id),
    .in_slot       (in_slot),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_id_out    (out_id_out),
    .out_index_out (out_index_out),
    .out_status    (out_status),
    .out_reliable  (out_reliable)
  );

  function automatic table_reply_t apply_command(input logic [2:0] cmd,
                                                 input logic [7:0] cpu_id,
                                                 input logic [5:0] slot);
    table_reply_t reply;
    int i, j, distinct;
    logic [7:0] v;
    reply = NO_REPLY;
    case (cmd)
      cidt_pkg::CMD_LOAD: begin
        // A load after finish throws the old table away and starts a new one.
        if (table_closed) begin
          entry_total = 0;
          table_closed = 1'b0;
        end
        if (entry_total >= TABLE_DEPTH) begin
          reply.status = cidt_pkg::ST_TABLE_FULL;
        end else begin
          proc_ids[entry_total] = cpu_id;
          entry_total++;
        end
      end
      cidt_pkg::CMD_FINISH: begin
        if (!table_closed) begin
          for (i = 0; i < entry_total; i++) begin
            v = proc_ids[i];
            j = i;
            while (j > 0 && sorted_ids[j - 1] > v) begin
              sorted_ids[j] = sorted_ids[j - 1];
              j--;
            end
            sorted_ids[j] = v;
          end
          distinct = 0;
          for (i = 0; i < entry_total; i++)
            if (i == 0 || sorted_ids[i] != sorted_ids[i - 1]) distinct++;
          if (distinct == 1 && sorted_ids[0] == 8'd0 && entry_total != 1)
            reply.status = cidt_pkg::ST_ALL_ZERO;
          else if (distinct != entry_total)
            reply.status = cidt_pkg::ST_NOT_UNIQUE;
          ids_trusted = (reply.status == cidt_pkg::ST_OK);
          if (!ids_trusted) begin
            for (i = 0; i < entry_total; i++) begin
              proc_ids[i] = 8'(i);
              sorted_ids[i] = 8'(i);
            end
          end
          table_closed = 1'b1;
        end
      end
      cidt_pkg::CMD_PROC_FROM_ID, cidt_pkg::CMD_CONTIG_FROM_ID: begin
        if (!table_closed) begin
          reply.status = cidt_pkg::ST_NOT_READY;
        end else begin
          reply.status = cidt_pkg::ST_NOT_FOUND;
          // Scanning downward leaves the lowest matching index in place.
          for (i = entry_total - 1; i >= 0; i--) begin
            if (((cmd == cidt_pkg::CMD_PROC_FROM_ID) ? proc_ids[i] : sorted_ids[i])
                == cpu_id) begin
              reply.idx = 6'(i);
              reply.status = cidt_pkg::ST_OK;
            end
          end
        end
      end
      cidt_pkg::CMD_ID_FROM_PROC, cidt_pkg::CMD_ID_FROM_CONTIG: begin
        if (!table_closed) begin
          reply.status = cidt_pkg::ST_NOT_READY;
        end else if (slot >= entry_total) begin
          reply.status = cidt_pkg::ST_BAD_INDEX;
        end else begin
          reply.id = (cmd == cidt_pkg::CMD_ID_FROM_PROC) ? proc_ids[slot] : sorted_ids[slot];
          reply.idx = slot;
        end
      end
      default: ;
    endcase
    reply.reliable = ids_trusted;
    return reply;
  endfunction

  // Offers one transaction, holds it until accepted and records what must come back.
  task automatic send_command(input logic [2:0] cmd, input logic [7:0] cpu_id,
                              input logic [5:0] slot, input bit fixed = 1'b0,
                              input table_reply_t fixed_reply = NO_REPLY);
    table_reply_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_cpu_id <= cpu_id;
    in_slot   <= slot;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predicted = apply_command(cmd, cpu_id, slot);
    replies_due.push_back(fixed ? fixed_reply : predicted);
    if (cmd <= cidt_pkg::CMD_ID_FROM_CONTIG) items_sent++;
  endtask

  // One table: loads, usually a finish, then lookups that mostly hit the table.
  task automatic run_table_session();
    int n, i, kind, lookups;
    logic [7:0] ids [TABLE_DEPTH];
    bit [255:0] taken;
    logic [7:0] v;
    logic [2:0] query;
    n = ($urandom_range(19) == 0) ? TABLE_DEPTH : $urandom_range(1, 8);
    kind = $urandom_range(9);
    taken = '0;
    for (i = 0; i < n; i++) begin
      if (kind == 8) begin
        v = 8'd0;
      end else if (kind >= 6 && kind <= 7 && i > 0 && $urandom_range(1) == 0) begin
        v = ids[$urandom_range(i - 1)];
      end else if (kind == 9) begin
        v = 8'($urandom_range(255));
      end else begin
        v = 8'($urandom_range(255));
        while (taken[v]) v = 8'($urandom_range(255));
      end
      taken[v] = 1'b1;
      ids[i] = v;
      send_command(cidt_pkg::CMD_LOAD, v, 6'($urandom_range(63)));
    end
    if (n == TABLE_DEPTH)
      repeat ($urandom_range(1, 3))
        send_command(cidt_pkg::CMD_LOAD, 8'($urandom_range(255)), 6'($urandom_range(63)));
    if ($urandom_range(7) != 0) begin
      send_command(cidt_pkg::CMD_FINISH, 8'($urandom_range(255)), 6'($urandom_range(63)));
      if ($urandom_range(3) == 0)
        send_command(cidt_pkg::CMD_FINISH, 8'($urandom_range(255)),
                     6'($urandom_range(63)));
    end
    lookups = $urandom_range(2, 10);
    for (i = 0; i < lookups; i++) begin
      query = 3'(cidt_pkg::CMD_PROC_FROM_ID) + 3'($urandom_range(3));
      send_command(query,
                   ($urandom_range(3) != 0) ? ids[$urandom_range(n - 1)]
                                             : 8'($urandom_range(255)),
                   ($urandom_range(3) != 0) ? 6'($urandom_range(n - 1))
                                             : 6'($urandom_range(63)));
    end
  endtask

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Handshake signals are stable between edges, so a transaction seen here is taken
  // at the next rising edge.
  always @(negedge clk) begin : result_check
    table_reply_t due;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("result transaction with no command outstanding");
          errors++;
        end else begin
          due = replies_due.pop_front();
          if (out_id_out !== due.id) begin
            $error("id_out: expected %0d, actual %0d", due.id, out_id_out);
            errors++;
          end
          if (out_index_out !== due.idx) begin
            $error("index_out: expected %0d, actual %0d", due.idx, out_index_out);
            errors++;
          end
          if (out_status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, out_status);
            errors++;
          end
          if (out_reliable !== due.reliable) begin
            $error("reliable: expected %0d, actual %0d", due.reliable, out_reliable);
            errors++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int r, phase, last_phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (r = 0; r < PROBE_COUNT; r++)
      send_command(PROBES[r].cmd, PROBES[r].cpu_id, PROBES[r].slot, PROBES[r].fixed,
                   PROBES[r].reply);

    items_sent = 0;
    last_phase = -1;
    while (items_sent < ITEM_TARGET) begin
      phase = items_sent * 8 / ITEM_TARGET;
      if (phase != last_phase) begin
        last_phase = phase;
        case (phase % 4)
          0: begin
            // Full-rate sender against a long hold-off fills the block up.
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
            hold_request = 1'b1;
          end
          1: begin
            sender_idle_pct = 69;
            receiver_stall_pct = 0;
          end
          2: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 69;
          end
          default: begin
            sender_idle_pct = 12;
            receiver_stall_pct = 12;
          end
        endcase
      end
      if ($urandom_range(9) != 0)
        run_table_session();
      else
        repeat ($urandom_range(1, 4))
          send_command(3'($urandom_range(7)), 8'($urandom_range(255)),
                       6'($urandom_range(63)));
    end
    in_valid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
